// ----- sv/bmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// bmbs_pkg
// Shared types and constants for the bus master burst sequencer.
// ----------------------------------------------------------------------------
package bmbs_pkg;

    localparam int DATA_WIDTH = 32;

    localparam logic [1:0] TR_IDLE   = 2'd0;
    localparam logic [1:0] TR_NONSEQ = 2'd2;
    localparam logic [1:0] TR_SEQ    = 2'd3;

    localparam logic [1:0] RESP_OKAY  = 2'd0;
    localparam logic [1:0] RESP_SPLIT = 2'd3;

    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef struct packed {
        logic        soft_reset;
        logic        task_valid;
        logic        task_is_write;
        logic [2:0]  task_burst_code;
        logic [1:0]  task_size_code;
        logic [31:0] task_bus_address;
        logic [31:0] task_local_address;
        logic        bus_grant;
        logic        bus_ready;
        logic [1:0]  bus_response;
        logic [31:0] bus_read_data;
        logic [31:0] local_read_data;
    } t_in;

    typedef struct packed {
        logic        bus_request;
        logic        bus_lock;
        logic [1:0]  transfer_type;
        logic        bus_write;
        logic [2:0]  burst_code_out;
        logic [1:0]  size_code_out;
        logic [31:0] bus_address;
        logic [31:0] bus_write_data;
        logic        local_write_enable;
        logic [31:0] local_address;
        logic [31:0] local_write_data;
        logic [2:0]  local_byte_count;
    } t_out;

    function automatic logic [4:0] beat_count(input logic [1:0] sel);
        logic [4:0] cnt;
        case (sel)
            2'd0:    cnt = 5'd1;
            2'd1:    cnt = 5'd4;
            2'd2:    cnt = 5'd8;
            2'd3:    cnt = 5'd16;
            default: cnt = 5'd1;
        endcase
        return cnt;
    endfunction

endpackage

// ----- sv/bmbs_core.sv -----
// ----------------------------------------------------------------------------
// bmbs_core
// Burst control state machine: takes one bus cycle per transaction and
// produces the next registered bus outputs.
// ----------------------------------------------------------------------------
module bmbs_core #(
    parameter int DATA_WIDTH = bmbs_pkg::DATA_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bmbs_pkg::t_in   i_item,
    output bmbs_pkg::t_out  o_result
);

    localparam int DW_EFF = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

    typedef enum logic [2:0] {
        PH_FREE,
        PH_REQ,
        PH_ADDR,
        PH_DATA,
        PH_SPLIT,
        PH_GAP
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [4:0]          r_bt, n_bt;
    logic [4:0]          r_bi, n_bi;
    logic                r_lw, n_lw;
    logic [2:0]          r_lb, n_lb;
    logic [1:0]          r_ls, n_ls;
    logic [31:0]         r_cba, n_cba;
    logic [31:0]         r_cla, n_cla;
    logic [DW_EFF-1:0]   r_held, n_held;
    logic [DW_EFF-1:0]   r_stored, n_stored;
    logic                r_req, n_req;
    logic                r_lock, n_lock;
    logic [1:0]          r_trans, n_trans;
    logic                r_pw, n_pw;
    logic [2:0]          r_pb, n_pb;
    logic [1:0]          r_ps, n_ps;
    logic [31:0]         r_pba, n_pba;
    logic                we;
    logic                do_grant;
    logic                do_check;
    logic                do_resp;
    logic [31:0]         step;

    assign step = 32'd1 << r_ls;

    always_comb begin
        n_phase  = r_phase;
        n_bt     = r_bt;
        n_bi     = r_bi;
        n_lw     = r_lw;
        n_lb     = r_lb;
        n_ls     = r_ls;
        n_cba    = r_cba;
        n_cla    = r_cla;
        n_held   = r_held;
        n_stored = r_stored;
        n_req    = r_req;
        n_lock   = r_lock;
        n_trans  = r_trans;
        n_pw     = r_pw;
        n_pb     = r_pb;
        n_ps     = r_ps;
        n_pba    = r_pba;
        we       = 1'b0;
        do_grant = 1'b0;
        do_check = 1'b0;
        do_resp  = 1'b0;

        case (r_phase)
            PH_REQ: begin
                do_grant = i_item.bus_grant;
            end
            PH_ADDR: begin
                do_check = 1'b1;
            end
            PH_DATA: begin
                if (!r_lw) begin
                    n_stored = i_item.bus_read_data[DW_EFF-1:0];
                    we       = 1'b1;
                end
                do_resp = 1'b1;
            end
            PH_SPLIT: begin
                do_resp = 1'b1;
            end
            PH_GAP: begin
                n_phase = PH_FREE;
            end
            default: begin
                n_phase = PH_FREE;
                if (i_item.task_valid) begin
                    n_pw  = i_item.task_is_write;
                    n_pb  = i_item.task_burst_code;
                    n_ps  = (i_item.task_size_code > bmbs_pkg::SIZE_WORD) ? bmbs_pkg::SIZE_WORD
                                                                          : i_item.task_size_code;
                    n_pba = i_item.task_bus_address;
                    n_cla = i_item.task_local_address;
                    n_bt  = bmbs_pkg::beat_count(i_item.task_burst_code[2:1]);
                    if (i_item.bus_grant) begin
                        do_grant = 1'b1;
                    end else begin
                        n_req   = 1'b1;
                        n_lock  = (n_bt > 5'd1);
                        n_phase = PH_REQ;
                    end
                end
            end
        endcase

        if (do_grant) begin
            n_lw     = n_pw;
            n_lb     = n_pb;
            n_ls     = n_ps;
            n_cba    = n_pba;
            n_bi     = 5'd0;
            n_trans  = bmbs_pkg::TR_NONSEQ;
            do_check = 1'b1;
        end

        if (do_check) begin
            if (!i_item.bus_ready) begin
                n_phase = PH_ADDR;
            end else begin
                if (n_lw) begin
                    n_held = i_item.local_read_data[DW_EFF-1:0];
                end
                n_phase = PH_DATA;
            end
        end

        if (do_resp) begin
            if (i_item.bus_response == bmbs_pkg::RESP_SPLIT) begin
                n_phase = PH_SPLIT;
            end else if (i_item.bus_response == bmbs_pkg::RESP_OKAY) begin
                n_cba = r_cba + step;
                n_cla = r_cla + step;
                n_bi  = r_bi + 5'd1;
                if (n_bi >= r_bt) begin
                    n_req   = 1'b0;
                    n_lock  = 1'b0;
                    n_trans = bmbs_pkg::TR_IDLE;
                    n_phase = PH_GAP;
                end else begin
                    n_trans = bmbs_pkg::TR_SEQ;
                    n_phase = PH_ADDR;
                end
            end else begin
                n_phase = PH_ADDR;
            end
        end

        if (i_item.soft_reset) begin
            n_phase  = PH_FREE;
            n_bt     = 5'd0;
            n_bi     = 5'd0;
            n_lw     = 1'b0;
            n_lb     = 3'd0;
            n_ls     = bmbs_pkg::SIZE_WORD;
            n_cba    = 32'd0;
            n_cla    = 32'd0;
            n_held   = '0;
            n_stored = '0;
            n_req    = 1'b0;
            n_lock   = 1'b0;
            n_trans  = bmbs_pkg::TR_IDLE;
            n_pw     = 1'b0;
            n_pb     = 3'd0;
            n_ps     = bmbs_pkg::SIZE_WORD;
            n_pba    = 32'd0;
            we       = 1'b0;
        end
    end

    always_comb begin
        o_result.bus_request        = n_req;
        o_result.bus_lock           = n_lock;
        o_result.transfer_type      = n_trans;
        o_result.bus_write          = n_lw;
        o_result.burst_code_out     = n_lb;
        o_result.size_code_out      = n_ls;
        o_result.bus_address        = n_cba;
        o_result.bus_write_data     = 32'(n_held);
        o_result.local_write_enable = we;
        o_result.local_address      = n_cla;
        o_result.local_write_data   = 32'(n_stored);
        o_result.local_byte_count   = 3'd1 << n_ls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FREE;
            r_bt     <= 5'd0;
            r_bi     <= 5'd0;
            r_lw     <= 1'b0;
            r_lb     <= 3'd0;
            r_ls     <= bmbs_pkg::SIZE_WORD;
            r_cba    <= 32'd0;
            r_cla    <= 32'd0;
            r_held   <= '0;
            r_stored <= '0;
            r_req    <= 1'b0;
            r_lock   <= 1'b0;
            r_trans  <= bmbs_pkg::TR_IDLE;
            r_pw     <= 1'b0;
            r_pb     <= 3'd0;
            r_ps     <= bmbs_pkg::SIZE_WORD;
            r_pba    <= 32'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_bt     <= n_bt;
            r_bi     <= n_bi;
            r_lw     <= n_lw;
            r_lb     <= n_lb;
            r_ls     <= n_ls;
            r_cba    <= n_cba;
            r_cla    <= n_cla;
            r_held   <= n_held;
            r_stored <= n_stored;
            r_req    <= n_req;
            r_lock   <= n_lock;
            r_trans  <= n_trans;
            r_pw     <= n_pw;
            r_pb     <= n_pb;
            r_ps     <= n_ps;
            r_pba    <= n_pba;
        end
    end

endmodule

// ----- sv/bmbs_skid.sv -----
// ----------------------------------------------------------------------------
// bmbs_skid
// Two-entry result buffer; ready toward the core is a register, so the
// input side never waits combinationally on the output side.
// ----------------------------------------------------------------------------
module bmbs_skid (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bmbs_pkg::t_out  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bmbs_pkg::t_out  o_data
);

    logic           r_main_valid;
    logic           r_skid_valid;
    bmbs_pkg::t_out r_main;
    bmbs_pkg::t_out r_skid;
    logic           push;
    logic           pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_valid;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
                if (push) begin
                    r_main <= i_data;
                end
            end
        end else if (push) begin
            if (!r_main_valid) begin
                r_main       <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ----- sv/bus_master_burst_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// bus_master_burst_sequencer_top
// Burst sequencer for a pipelined shared-bus master.
// ----------------------------------------------------------------------------
// Each input transaction is one sampled bus cycle and yields exactly one
// result transaction holding the bus outputs after that cycle. The state
// machine in bmbs_core updates once per accepted transaction, so one
// transaction is accepted every cycle while the buffer has a free slot;
// each result is registered in a two-entry output buffer, whose free slot
// alone sets input ready. Throughput is one transaction per clock while
// the output side takes results.
module bus_master_burst_sequencer_top #(
    parameter int DATA_WIDTH = bmbs_pkg::DATA_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bmbs_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bmbs_pkg::t_out  o_out_data
);

    logic           accept;
    bmbs_pkg::t_out result;

    assign accept = i_in_valid && o_in_ready;

    bmbs_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_item   (i_in_data),
        .o_result (result)
    );

    bmbs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .o_ready (o_in_ready),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_lock_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bus_lock |-> o_out_data.bus_request)
        else $error("lock without request");

    a_we_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.local_write_enable |-> !o_out_data.bus_write)
        else $error("local write during write burst");

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted transaction produced no result");
`endif

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bus master burst sequencer.
// ----------------------------------------------------------------------------
// Every input transaction is one sampled bus cycle. The bench keeps its own
// cycle model of the sequencer: it latches tasks, handles the request and
// grant, runs the beats with wait states, ERROR/RETRY repeats and SPLIT
// holds, and then inserts the idle gap. The model predicts the registered
// bus outputs for each accepted cycle, and every result transaction is
// compared field by field in order. A short directed table comes first.
// It covers reset, single and 16-beat bursts, address wrap, every response
// code, an oversized size code and tasks offered while busy. A long random
// run of mostly well-formed bursts follows, with idle cycles on the input
// side and stalls on the output side.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1750;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic [1:0] RESP_ERROR = 2'd1;
    localparam logic [1:0] RESP_RETRY = 2'd2;

    localparam logic [3:0][4:0] BEATS_BY_SEL = {5'd16, 5'd8, 5'd4, 5'd1};

    // request, lock, trans, write, burst, size, haddr, hwdata, we, laddr, lwdata, bytes
    localparam bmbs_pkg::t_out OUT_AT_RESET = {1'b0, 1'b0, bmbs_pkg::TR_IDLE, 1'b0, 3'd0,
                                               bmbs_pkg::SIZE_WORD, 32'd0, 32'd0, 1'b0,
                                               32'd0, 32'd0, 3'd4};
    localparam bmbs_pkg::t_out OUT_REQ_ONE  = {1'b1, 1'b0, bmbs_pkg::TR_IDLE, 1'b0, 3'd0,
                                               bmbs_pkg::SIZE_WORD, 32'd0, 32'd0, 1'b0,
                                               32'hFFFF_FFFF, 32'd0, 3'd4};

    typedef enum logic [2:0] {
        PH_FREE, PH_REQ, PH_ADDR, PH_DATA, PH_SPLIT, PH_GAP
    } t_phase;

    logic           clk;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    bmbs_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    bmbs_pkg::t_out out_data;

    // sequencer model state
    t_phase      ph;
    logic [4:0]  beats_total, beat_idx;
    logic        lat_wr;
    logic [2:0]  lat_burst;
    logic [1:0]  lat_size;
    logic [31:0] cur_baddr, cur_laddr, held_wdata, stored_rdata;
    logic        req_r, lock_r;
    logic [1:0]  trans_r;
    logic        pend_wr;
    logic [2:0]  pend_burst;
    logic [1:0]  pend_size;
    logic [31:0] pend_baddr;

    bmbs_pkg::t_out bus_cycle_q[$];
    bmbs_pkg::t_in  dir_stim[$];
    bmbs_pkg::t_out dir_pin[$];
    bit             dir_pinned[$];

    int mismatches = 0;
    int n_results  = 0;
    int cycles     = 0;

    bus_master_burst_sequencer_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_model();
        ph           = PH_FREE;
        beats_total  = '0;
        beat_idx     = '0;
        lat_wr       = 1'b0;
        lat_burst    = '0;
        lat_size     = bmbs_pkg::SIZE_WORD;
        cur_baddr    = '0;
        cur_laddr    = '0;
        held_wdata   = '0;
        stored_rdata = '0;
        req_r        = 1'b0;
        lock_r       = 1'b0;
        trans_r      = bmbs_pkg::TR_IDLE;
        pend_wr      = 1'b0;
        pend_burst   = '0;
        pend_size    = bmbs_pkg::SIZE_WORD;
        pend_baddr   = '0;
    endfunction

    function automatic void sample_addr(input bmbs_pkg::t_in c);
        if (!c.bus_ready) begin
            ph = PH_ADDR;
        end else begin
            if (lat_wr) held_wdata = c.local_read_data;
            ph = PH_DATA;
        end
    endfunction

    function automatic void start_grant(input bmbs_pkg::t_in c);
        lat_wr    = pend_wr;
        lat_burst = pend_burst;
        lat_size  = pend_size;
        cur_baddr = pend_baddr;
        beat_idx  = '0;
        trans_r   = bmbs_pkg::TR_NONSEQ;
        sample_addr(c);
    endfunction

    function automatic void take_response(input logic [1:0] resp);
        logic [31:0] step;
        step = 32'd1 << lat_size;
        if (resp == bmbs_pkg::RESP_SPLIT) begin
            ph = PH_SPLIT;
        end else if (resp == bmbs_pkg::RESP_OKAY) begin
            cur_baddr = cur_baddr + step;
            cur_laddr = cur_laddr + step;
            beat_idx  = beat_idx + 5'd1;
            if (beat_idx >= beats_total) begin
                req_r   = 1'b0;
                lock_r  = 1'b0;
                trans_r = bmbs_pkg::TR_IDLE;
                ph      = PH_GAP;
            end else begin
                trans_r = bmbs_pkg::TR_SEQ;
                ph      = PH_ADDR;
            end
        end else begin
            ph = PH_ADDR;
        end
    endfunction

    function automatic bmbs_pkg::t_out predict_bus_cycle(input bmbs_pkg::t_in c);
        bmbs_pkg::t_out o;
        logic we;
        we = 1'b0;
        if (c.soft_reset) begin
            clear_model();
        end else begin
            case (ph)
                PH_REQ: begin
                    if (c.bus_grant) start_grant(c);
                end
                PH_ADDR: sample_addr(c);
                PH_DATA: begin
                    if (!lat_wr) begin
                        stored_rdata = c.bus_read_data;
                        we = 1'b1;
                    end
                    take_response(c.bus_response);
                end
                PH_SPLIT: take_response(c.bus_response);
                PH_GAP:   ph = PH_FREE;
                default: begin
                    ph = PH_FREE;
                    if (c.task_valid) begin
                        pend_wr     = c.task_is_write;
                        pend_burst  = c.task_burst_code;
                        pend_size   = (c.task_size_code > bmbs_pkg::SIZE_WORD)
                                      ? bmbs_pkg::SIZE_WORD : c.task_size_code;
                        pend_baddr  = c.task_bus_address;
                        cur_laddr   = c.task_local_address;
                        beats_total = BEATS_BY_SEL[pend_burst[2:1]];
                        if (c.bus_grant) begin
                            start_grant(c);
                        end else begin
                            req_r  = 1'b1;
                            lock_r = (beats_total > 5'd1);
                            ph     = PH_REQ;
                        end
                    end
                end
            endcase
        end
        o.bus_request        = req_r;
        o.bus_lock           = lock_r;
        o.transfer_type      = trans_r;
        o.bus_write          = lat_wr;
        o.burst_code_out     = lat_burst;
        o.size_code_out      = lat_size;
        o.bus_address        = cur_baddr;
        o.bus_write_data     = held_wdata;
        o.local_write_enable = we;
        o.local_address      = cur_laddr;
        o.local_write_data   = stored_rdata;
        o.local_byte_count   = 3'd1 << lat_size;
        return o;
    endfunction

    function automatic void add_row(input logic rst, input logic tv, input logic wr,
                                    input logic [2:0] burst, input logic [1:0] size,
                                    input logic [31:0] baddr, input logic [31:0] laddr,
                                    input logic gnt, input logic rdy,
                                    input logic [1:0] resp,
                                    input logic [31:0] rdata, input logic [31:0] ldata);
        bmbs_pkg::t_in c;
        c.soft_reset         = rst;
        c.task_valid         = tv;
        c.task_is_write      = wr;
        c.task_burst_code    = burst;
        c.task_size_code     = size;
        c.task_bus_address   = baddr;
        c.task_local_address = laddr;
        c.bus_grant          = gnt;
        c.bus_ready          = rdy;
        c.bus_response       = resp;
        c.bus_read_data      = rdata;
        c.local_read_data    = ldata;
        dir_stim.push_back(c);
        dir_pinned.push_back(1'b0);
        dir_pin.push_back('0);
    endfunction

    function automatic void pin_last(input bmbs_pkg::t_out want);
        dir_pinned[dir_pinned.size() - 1] = 1'b1;
        dir_pin[dir_pin.size() - 1]       = want;
    endfunction

    function automatic logic [31:0] rand_addr();
        if ($urandom_range(0, 7) == 0) return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    function automatic bmbs_pkg::t_in next_bus_cycle();
        bmbs_pkg::t_in c;
        c.soft_reset         = ($urandom_range(0, 299) == 0);
        c.task_valid         = (ph == PH_FREE) ? ($urandom_range(0, 9) < 8)
                                               : ($urandom_range(0, 3) == 0);
        c.task_is_write      = 1'($urandom_range(0, 1));
        c.task_burst_code    = 3'($urandom_range(0, 7));
        c.task_size_code     = 2'($urandom_range(0, 3));
        c.task_bus_address   = rand_addr();
        c.task_local_address = rand_addr();
        c.bus_grant          = ($urandom_range(0, 9) < 6);
        c.bus_ready          = ($urandom_range(0, 9) < 8);
        c.bus_response       = ($urandom_range(0, 9) < 7) ? bmbs_pkg::RESP_OKAY
                                                          : 2'($urandom_range(1, 3));
        c.bus_read_data      = $urandom;
        c.local_read_data    = $urandom;
        return c;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] result %0d: %s got %h expected %h", $time, n_results, field,
                 got, want);
        mismatches++;
    endtask

    task automatic check_bus_cycle(input bmbs_pkg::t_out got);
        bmbs_pkg::t_out want;
        if (bus_cycle_q.size() == 0) begin
            report_mismatch("unexpected transaction", got.bus_address, 32'd0);
            return;
        end
        want = bus_cycle_q.pop_front();
        if (got.bus_request !== want.bus_request)
            report_mismatch("bus_request", 32'(got.bus_request), 32'(want.bus_request));
        if (got.bus_lock !== want.bus_lock)
            report_mismatch("bus_lock", 32'(got.bus_lock), 32'(want.bus_lock));
        if (got.transfer_type !== want.transfer_type)
            report_mismatch("transfer_type", 32'(got.transfer_type),
                            32'(want.transfer_type));
        if (got.bus_write !== want.bus_write)
            report_mismatch("bus_write", 32'(got.bus_write), 32'(want.bus_write));
        if (got.burst_code_out !== want.burst_code_out)
            report_mismatch("burst_code_out", 32'(got.burst_code_out),
                            32'(want.burst_code_out));
        if (got.size_code_out !== want.size_code_out)
            report_mismatch("size_code_out", 32'(got.size_code_out),
                            32'(want.size_code_out));
        if (got.bus_address !== want.bus_address)
            report_mismatch("bus_address", got.bus_address, want.bus_address);
        if (got.bus_write_data !== want.bus_write_data)
            report_mismatch("bus_write_data", got.bus_write_data, want.bus_write_data);
        if (got.local_write_enable !== want.local_write_enable)
            report_mismatch("local_write_enable", 32'(got.local_write_enable),
                            32'(want.local_write_enable));
        if (got.local_address !== want.local_address)
            report_mismatch("local_address", got.local_address, want.local_address);
        if (got.local_write_data !== want.local_write_data)
            report_mismatch("local_write_data", got.local_write_data,
                            want.local_write_data);
        if (got.local_byte_count !== want.local_byte_count)
            report_mismatch("local_byte_count", 32'(got.local_byte_count),
                            32'(want.local_byte_count));
        n_results++;
    endtask

    // result side: per-transaction stall draw, with stall-free stretches
    initial begin : result_side
        int hold;
        bit calm;
        hold = 0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                check_bus_cycle(out_data);
                if (n_results % 100 == 0) calm = ($urandom_range(0, 3) == 0);
                hold = calm ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                out_ready <= 1'b0;
                hold--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        bmbs_pkg::t_in  item;
        bmbs_pkg::t_out want;
        int             n_items;
        int             gap;
        bit             calm;

        clear_model();
        calm = 1'b0;

        //       rst   tv    wr    bst   sz    bus addr       local addr     gnt   rdy
        //       resp        read data      local data
        add_row(1'b1, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b0,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        pin_last(OUT_AT_RESET);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b0,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        pin_last(OUT_AT_RESET);
        // single write at the top of both address spaces, not yet granted
        add_row(1'b0, 1'b1, 1'b1, 3'd0, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        pin_last(OUT_REQ_ONE);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b1, 1'b0,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                RESP_ERROR,           32'd0,         32'hFFFF_FFFF);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'hFFFF_FFFF, 32'd0);
        // idle gap: offered task must be dropped
        add_row(1'b0, 1'b1, 1'b1, 3'd7, 2'd1, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        // 16-beat read, size code three, granted at once
        add_row(1'b0, 1'b1, 1'b0, 3'd7, 2'd3, 32'h8000_0001, 32'h7FFF_FFFE, 1'b1, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                RESP_ERROR,           32'hFFFF_FFFF, 32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                RESP_RETRY,           32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_SPLIT, 32'hA5A5_A5A5, 32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_SPLIT, 32'h5A5A_5A5A, 32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        // busy: offered task ignored, wait state
        add_row(1'b0, 1'b1, 1'b1, 3'd2, 2'd1, 32'h0000_0100, 32'h0000_0200, 1'b1, 1'b0,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'h0F0F_0F0F, 32'd0);
        // bus reset in the middle of a burst
        add_row(1'b1, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        pin_last(OUT_AT_RESET);
        // 4-beat halfword write, lock requested
        add_row(1'b0, 1'b1, 1'b1, 3'd2, 2'd1, 32'h0000_FFFE, 32'hFFFF_0000, 1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b1, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'hC3C3_C3C3);
        add_row(1'b0, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        add_row(1'b1, 1'b0, 1'b0, 3'd0, 2'd0, 32'd0,         32'd0,         1'b0, 1'b1,
                bmbs_pkg::RESP_OKAY,  32'd0,         32'd0);
        pin_last(OUT_AT_RESET);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        n_items = dir_stim.size() + N_RANDOM;
        for (int i = 0; i < n_items; i++) begin
            item = (i < dir_stim.size()) ? dir_stim[i] : next_bus_cycle();
            if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do @(posedge clk); while (!in_ready);
            want = predict_bus_cycle(item);
            if (i < dir_stim.size() && dir_pinned[i]) want = dir_pin[i];
            bus_cycle_q.push_back(want);
        end
        in_valid <= 1'b0;

        while (bus_cycle_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0 && bus_cycle_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/bmbs_pkg.sv
sv/bmbs_core.sv
sv/bmbs_skid.sv
sv/bus_master_burst_sequencer_top.sv
sim/tb.sv
